// ----- rtl/phase_triangulation_to_xyz_unit_macros.svh -----
// Assertion macros used by the port checker of the triangulation unit.
`ifndef PHASE_TRIANGULATION_TO_XYZ_UNIT_MACROS_SVH
`define PHASE_TRIANGULATION_TO_XYZ_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define PTXYZ_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PTXYZ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/ptxyz_pkg.sv -----
// Types, constants and arithmetic helpers of the phase triangulation unit.
package ptxyz_pkg;

  localparam int MAX_ROWS = 4096;
  localparam int MAX_COLS = 4096;
  // Wide enough for a last index of 65535 and for index + 1.
  localparam int IDX_W = 17;
  localparam logic [IDX_W-1:0] ROW_LAST = IDX_W'(MAX_ROWS - 1);
  localparam logic [IDX_W-1:0] COL_LAST = IDX_W'(MAX_COLS - 1);

  localparam int CFG_IDX_W = 3;
  localparam int OFS_W     = 34;   // cx - (j+1), cy - (i+1)
  localparam int C_W       = 66;   // cofactors
  localparam int M_W       = 50;   // third row of the system and right side
  localparam int PROD_W    = 116;  // cofactor times row entry
  localparam int DET_W     = 118;  // determinant and divisor magnitude
  localparam int NMAG_W    = 116;  // numerator magnitude
  localparam int Q_W       = 32;   // quotient bits produced by the divider
  localparam int DIV_STEPS = Q_W;
  localparam int DIV_LAT   = DIV_STEPS + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAM_FX_SKEW   = 3'd0,
    REG_CAM_CX_FY     = 3'd1,
    REG_CAM_CY_SCALE  = 3'd2,
    REG_PROJ_R2_FIRST = 3'd3,
    REG_PROJ_R2_SECND = 3'd4,
    REG_PROJ_R3_FIRST = 3'd5,
    REG_PROJ_R3_SECND = 3'd6
  } ptxyz_reg_e;

  typedef struct packed {
    logic [11:0]        pixel_row;
    logic [11:0]        pixel_col;
    logic signed [31:0] abs_phase;
  } ptxyz_in_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               singular;
  } ptxyz_out_t;

  // Partial products of a C_W by M_W signed multiply.
  typedef struct packed {
    logic [56:0]        ll;
    logic signed [57:0] lh;
    logic signed [59:0] hl;
    logic signed [58:0] hh;
  } ptxyz_pp_t;

  function automatic ptxyz_pp_t pp_mul(input logic signed [C_W-1:0] c,
                                       input logic signed [M_W-1:0] m);
    ptxyz_pp_t r;
    r.ll = c[31:0] * m[24:0];
    r.lh = $signed({1'b0, c[31:0]}) * $signed(m[49:25]);
    r.hl = $signed(c[65:32]) * $signed({1'b0, m[24:0]});
    r.hh = $signed(c[65:32]) * $signed(m[49:25]);
    return r;
  endfunction

  function automatic logic signed [PROD_W-1:0] pp_sum(input ptxyz_pp_t pp);
    logic [PROD_W-1:0] s;
    s = (PROD_W'(pp.hh) << 57) + (PROD_W'(pp.hl) << 32)
      + (PROD_W'(pp.lh) << 25) + PROD_W'(pp.ll);
    return $signed(s);
  endfunction

  // Round half up from Q32.32 to Q16.16 (floor of (x + 2^15) / 2^16).
  function automatic logic signed [48:0] rnd16(input logic signed [63:0] x);
    logic signed [64:0] t;
    t = 65'(x) + 65'sd32768;
    return $signed(t[64:16]);
  endfunction

endpackage

// ----- rtl/ptxyz_div.sv -----
// Pipelined restoring divider: one quotient bit per stage plus a rounding stage.
module ptxyz_div (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [ptxyz_pkg::NMAG_W-1:0]   num_i,
  input  logic [ptxyz_pkg::DET_W-1:0]    den_i,
  output logic [ptxyz_pkg::Q_W-1:0]      quo_o,
  output logic                           round_o
);

  logic [ptxyz_pkg::DET_W-1:0] rem_q  [ptxyz_pkg::DIV_STEPS];
  logic [ptxyz_pkg::DET_W-1:0] den_q  [ptxyz_pkg::DIV_STEPS];
  logic [ptxyz_pkg::Q_W-1:0]   feed_q [ptxyz_pkg::DIV_STEPS];
  logic [ptxyz_pkg::Q_W-1:0]   quo_q  [ptxyz_pkg::DIV_STEPS];
  logic [ptxyz_pkg::Q_W-1:0]   quo_out_q;
  logic                        round_q;

  for (genvar k = 0; k < ptxyz_pkg::DIV_STEPS; k++) begin : g_step
    logic [ptxyz_pkg::DET_W-1:0] rem_in;
    logic [ptxyz_pkg::DET_W-1:0] den_in;
    logic [ptxyz_pkg::Q_W-1:0]   feed_in;
    logic [ptxyz_pkg::Q_W-1:0]   quo_in;
    logic [ptxyz_pkg::DET_W:0]   trial;
    logic [ptxyz_pkg::DET_W:0]   diff;
    logic                        ge;

    if (k == 0) begin : g_first
      // Upper numerator bits seed the remainder; the low bits and the
      // Q16.16 scaling zeros are shifted in one per step.
      assign rem_in  = ptxyz_pkg::DET_W'(num_i[ptxyz_pkg::NMAG_W-1:16]);
      assign den_in  = den_i;
      assign feed_in = {num_i[15:0], 16'b0};
      assign quo_in  = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign feed_in = feed_q[k-1];
      assign quo_in  = quo_q[k-1];
    end

    assign trial = {rem_in, feed_in[ptxyz_pkg::Q_W-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[ptxyz_pkg::DET_W-1:0] : trial[ptxyz_pkg::DET_W-1:0];
        den_q[k]  <= den_in;
        feed_q[k] <= {feed_in[ptxyz_pkg::Q_W-2:0], 1'b0};
        quo_q[k]  <= {quo_in[ptxyz_pkg::Q_W-2:0], ge};
      end
    end
  end

  // Round half away from zero on the magnitude: twice the remainder vs divisor.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_out_q <= quo_q[ptxyz_pkg::DIV_STEPS-1];
      round_q   <= {rem_q[ptxyz_pkg::DIV_STEPS-1], 1'b0}
                   >= {1'b0, den_q[ptxyz_pkg::DIV_STEPS-1]};
    end
  end

  assign quo_o   = quo_out_q;
  assign round_o = round_q;

endmodule

// ----- rtl/phase_triangulation_to_xyz_unit.sv -----
// Top level of the structured-light phase triangulation unit.
// Stages from an input transfer to its result on the output register:
// ten capture and arithmetic stages, 32 quotient stages and a rounding stage, then the output.
// Throughput: one pixel per cycle; a blocked output register freezes every stage.
// Reset: asynchronous, active low; clears all valid bits and the seven
// configuration registers to zero; no clearing pass.
module phase_triangulation_to_xyz_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  ptxyz_pkg::ptxyz_in_t                 in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output ptxyz_pkg::ptxyz_out_t                out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ptxyz_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [63:0]                          cfg_data_i
);

  typedef struct packed {
    logic       valid;
    logic       sing;
    logic [2:0] neg;
    logic [2:0] ovf;
  } ptxyz_sb_t;

  // ---------------------------------------------------------------------------
  // Configuration registers: always ready, out-of-range index is dropped.
  // ---------------------------------------------------------------------------
  logic [63:0] fx_skew_q, cx_fy_q, cy_scale_q, r2_first_q, r2_secnd_q;
  logic [63:0] r3_first_q, r3_secnd_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fx_skew_q  <= '0;
      cx_fy_q    <= '0;
      cy_scale_q <= '0;
      r2_first_q <= '0;
      r2_secnd_q <= '0;
      r3_first_q <= '0;
      r3_secnd_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        ptxyz_pkg::REG_CAM_FX_SKEW:   fx_skew_q  <= cfg_data_i;
        ptxyz_pkg::REG_CAM_CX_FY:     cx_fy_q    <= cfg_data_i;
        ptxyz_pkg::REG_CAM_CY_SCALE:  cy_scale_q <= cfg_data_i;
        ptxyz_pkg::REG_PROJ_R2_FIRST: r2_first_q <= cfg_data_i;
        ptxyz_pkg::REG_PROJ_R2_SECND: r2_secnd_q <= cfg_data_i;
        ptxyz_pkg::REG_PROJ_R3_FIRST: r3_first_q <= cfg_data_i;
        ptxyz_pkg::REG_PROJ_R3_SECND: r3_secnd_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Unpack the Q16.16 words.
  logic signed [31:0] fx, sk, cx, fy, cy, sc, a1, a2, a3, a4, b1, b2, b3, b4;
  assign fx = $signed(fx_skew_q[63:32]);
  assign sk = $signed(fx_skew_q[31:0]);
  assign cx = $signed(cx_fy_q[63:32]);
  assign fy = $signed(cx_fy_q[31:0]);
  assign cy = $signed(cy_scale_q[63:32]);
  assign sc = $signed(cy_scale_q[31:0]);
  assign a1 = $signed(r2_first_q[63:32]);
  assign a2 = $signed(r2_first_q[31:0]);
  assign a3 = $signed(r2_secnd_q[63:32]);
  assign a4 = $signed(r2_secnd_q[31:0]);
  assign b1 = $signed(r3_first_q[63:32]);
  assign b2 = $signed(r3_first_q[31:0]);
  assign b3 = $signed(r3_secnd_q[63:32]);
  assign b4 = $signed(r3_secnd_q[31:0]);

  // ---------------------------------------------------------------------------
  // Global advance: hold everything while a finished result waits.
  // ---------------------------------------------------------------------------
  logic en;
  logic out_vld_q;
  assign en         = !(out_vld_q && out_stall_i);
  assign in_stall_o = !en;

  // Valid bits of stages 1 to 10.
  logic [9:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[8:0], in_valid_i};
    end
  end

  // Stage 1: capture the transfer.
  logic [11:0]        s1_row_q, s1_col_q;
  logic signed [31:0] s1_ph_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_row_q <= in_data_i.pixel_row;
      s1_col_q <= in_data_i.pixel_col;
      s1_ph_q  <= in_data_i.abs_phase;
    end
  end

  // Stage 2: phase times scale, principal point offsets with 1-based indices.
  logic [ptxyz_pkg::IDX_W-1:0] row_c, col_c, row_1, col_1;
  logic [ptxyz_pkg::OFS_W-1:0] row_off, col_off;
  logic signed [63:0]          s2_pprod_q;
  logic signed [ptxyz_pkg::OFS_W-1:0] s2_m13_q, s2_m23_q;

  always_comb begin
    row_c = (ptxyz_pkg::IDX_W'(s1_row_q) > ptxyz_pkg::ROW_LAST) ?
            ptxyz_pkg::ROW_LAST : ptxyz_pkg::IDX_W'(s1_row_q);
    col_c = (ptxyz_pkg::IDX_W'(s1_col_q) > ptxyz_pkg::COL_LAST) ?
            ptxyz_pkg::COL_LAST : ptxyz_pkg::IDX_W'(s1_col_q);
    row_1   = row_c + 1'b1;
    col_1   = col_c + 1'b1;
    row_off = {1'b0, row_1, 16'b0};
    col_off = {1'b0, col_1, 16'b0};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_pprod_q <= s1_ph_q * sc;
      s2_m13_q   <= ptxyz_pkg::OFS_W'(cx) - $signed(col_off);
      s2_m23_q   <= ptxyz_pkg::OFS_W'(cy) - $signed(row_off);
    end
  end

  // Stage 3: projector coordinate, rounded and saturated.
  logic signed [48:0] ph_rnd;
  logic signed [31:0] s3_p_q;
  logic signed [ptxyz_pkg::OFS_W-1:0] s3_m13_q, s3_m23_q;

  assign ph_rnd = ptxyz_pkg::rnd16(s2_pprod_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (ph_rnd > 49'sd2147483647) begin
        s3_p_q <= 32'sh7FFFFFFF;
      end else if (ph_rnd < -49'sd2147483648) begin
        s3_p_q <= 32'sh80000000;
      end else begin
        s3_p_q <= $signed(ph_rnd[31:0]);
      end
      s3_m13_q <= s2_m13_q;
      s3_m23_q <= s2_m23_q;
    end
  end

  // Stage 4: projector row products and the cofactor products.
  logic signed [63:0]            s4_pb1_q, s4_pb2_q, s4_pb3_q, s4_pb4_q, s4_fxfy_q;
  logic signed [ptxyz_pkg::C_W-1:0] s4_skm_q, s4_m13fy_q, s4_fxm_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_pb1_q   <= s3_p_q * b1;
      s4_pb2_q   <= s3_p_q * b2;
      s4_pb3_q   <= s3_p_q * b3;
      s4_pb4_q   <= s3_p_q * b4;
      s4_skm_q   <= ptxyz_pkg::C_W'(sk) * ptxyz_pkg::C_W'(s3_m23_q);
      s4_m13fy_q <= ptxyz_pkg::C_W'(s3_m13_q) * ptxyz_pkg::C_W'(fy);
      s4_fxm_q   <= ptxyz_pkg::C_W'(fx) * ptxyz_pkg::C_W'(s3_m23_q);
      s4_fxfy_q  <= fx * fy;
    end
  end

  // Stage 5: third row of the system, right side, cofactors of that row.
  logic signed [ptxyz_pkg::M_W-1:0] s5_m3_q [3];
  logic signed [ptxyz_pkg::M_W-1:0] s5_r_q;
  logic signed [ptxyz_pkg::C_W-1:0] s5_c_q  [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_m3_q[0] <= ptxyz_pkg::M_W'(a1) - ptxyz_pkg::M_W'(ptxyz_pkg::rnd16(s4_pb1_q));
      s5_m3_q[1] <= ptxyz_pkg::M_W'(a2) - ptxyz_pkg::M_W'(ptxyz_pkg::rnd16(s4_pb2_q));
      s5_m3_q[2] <= ptxyz_pkg::M_W'(a3) - ptxyz_pkg::M_W'(ptxyz_pkg::rnd16(s4_pb3_q));
      s5_r_q     <= ptxyz_pkg::M_W'(ptxyz_pkg::rnd16(s4_pb4_q)) - ptxyz_pkg::M_W'(a4);
      s5_c_q[0]  <= s4_skm_q - s4_m13fy_q;
      s5_c_q[1]  <= -s4_fxm_q;
      s5_c_q[2]  <= ptxyz_pkg::C_W'(s4_fxfy_q);
    end
  end

  // Stage 6: partial products; entries 0..2 feed the determinant,
  // entries 3..5 the numerators of x, y, z.
  ptxyz_pkg::ptxyz_pp_t s6_pp_q [6];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s6_pp_q[k]   <= ptxyz_pkg::pp_mul(s5_c_q[k], s5_m3_q[k]);
        s6_pp_q[k+3] <= ptxyz_pkg::pp_mul(s5_c_q[k], s5_r_q);
      end
    end
  end

  // Stage 7: full products.
  logic signed [ptxyz_pkg::PROD_W-1:0] s7_prod_q [6];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        s7_prod_q[k] <= ptxyz_pkg::pp_sum(s6_pp_q[k]);
      end
    end
  end

  // Stage 8: determinant by expansion along the third row.
  logic signed [ptxyz_pkg::DET_W-1:0]  s8_det_q;
  logic signed [ptxyz_pkg::PROD_W-1:0] s8_num_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_det_q <= ptxyz_pkg::DET_W'(s7_prod_q[0]) + ptxyz_pkg::DET_W'(s7_prod_q[1])
                + ptxyz_pkg::DET_W'(s7_prod_q[2]);
      for (int k = 0; k < 3; k++) begin
        s8_num_q[k] <= s7_prod_q[k+3];
      end
    end
  end

  // Stage 9: signs and magnitudes.
  logic [ptxyz_pkg::DET_W-1:0]  s9_dmag_q;
  logic [ptxyz_pkg::NMAG_W-1:0] s9_nmag_q [3];
  logic [2:0]                   s9_neg_q;
  logic                         s9_sing_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s9_dmag_q <= s8_det_q[ptxyz_pkg::DET_W-1] ? $unsigned(-s8_det_q) : $unsigned(s8_det_q);
      s9_sing_q <= (s8_det_q == '0);
      for (int k = 0; k < 3; k++) begin
        s9_nmag_q[k] <= s8_num_q[k][ptxyz_pkg::PROD_W-1] ?
                        $unsigned(-s8_num_q[k]) : $unsigned(s8_num_q[k]);
        s9_neg_q[k]  <= s8_num_q[k][ptxyz_pkg::PROD_W-1] ^ s8_det_q[ptxyz_pkg::DET_W-1];
      end
    end
  end

  // Stage 10: a quotient of 2^32 or more saturates regardless of rounding.
  logic [ptxyz_pkg::DET_W-1:0]  s10_dmag_q;
  logic [ptxyz_pkg::NMAG_W-1:0] s10_nmag_q [3];
  ptxyz_sb_t                    s10_sb;
  logic [2:0]                   s10_ovf_q, s10_neg_q;
  logic                         s10_sing_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s10_dmag_q <= s9_dmag_q;
      s10_neg_q  <= s9_neg_q;
      s10_sing_q <= s9_sing_q;
      for (int k = 0; k < 3; k++) begin
        s10_nmag_q[k] <= s9_nmag_q[k];
        s10_ovf_q[k]  <= {(ptxyz_pkg::DET_W + 16 - ptxyz_pkg::NMAG_W)'(0), s9_nmag_q[k]}
                         >= {s9_dmag_q, 16'b0};
      end
    end
  end

  assign s10_sb = '{valid: vld_q[9], sing: s10_sing_q, neg: s10_neg_q, ovf: s10_ovf_q};

  // Dividers, one per coordinate, and the side information that keeps pace.
  logic [ptxyz_pkg::Q_W-1:0] quo [3];
  logic [2:0]                rup;

  for (genvar k = 0; k < 3; k++) begin : g_div
    ptxyz_div u_div (
      .clk_i   (clk_i),
      .en_i    (en),
      .num_i   (s10_nmag_q[k]),
      .den_i   (s10_dmag_q),
      .quo_o   (quo[k]),
      .round_o (rup[k])
    );
  end

  ptxyz_sb_t sb_q [ptxyz_pkg::DIV_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ptxyz_pkg::DIV_LAT; k++) begin
        sb_q[k] <= '0;
      end
    end else if (en) begin
      sb_q[0] <= s10_sb;
      for (int k = 1; k < ptxyz_pkg::DIV_LAT; k++) begin
        sb_q[k] <= sb_q[k-1];
      end
    end
  end

  // Round, saturate, apply the sign.
  function automatic logic [31:0] finish(input logic [ptxyz_pkg::Q_W-1:0] q,
                                         input logic up, input logic neg,
                                         input logic ovf);
    logic [32:0] q1, lim, qs, v;
    q1  = {1'b0, q} + 33'(up);
    lim = neg ? 33'h080000000 : 33'h07FFFFFFF;
    qs  = (ovf || (q1 > lim)) ? lim : q1;
    v   = neg ? (33'd0 - qs) : qs;
    return v[31:0];
  endfunction

  ptxyz_sb_t             sb_last;
  ptxyz_pkg::ptxyz_out_t res_d, out_q;

  assign sb_last = sb_q[ptxyz_pkg::DIV_LAT-1];

  always_comb begin
    res_d.singular = sb_last.sing;
    if (sb_last.sing) begin
      res_d.point_x = '0;
      res_d.point_y = '0;
      res_d.point_z = '0;
    end else begin
      res_d.point_x = $signed(finish(quo[0], rup[0], sb_last.neg[0], sb_last.ovf[0]));
      res_d.point_y = $signed(finish(quo[1], rup[1], sb_last.neg[1], sb_last.ovf[1]));
      res_d.point_z = $signed(finish(quo[2], rup[2], sb_last.neg[2], sb_last.ovf[2]));
    end
  end

  // Output register: load whenever the pipeline advances.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= sb_last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/ptxyz_checker.sv -----
// Port-level checks of the triangulation unit and their binding.
`include "phase_triangulation_to_xyz_unit_macros.svh"

module ptxyz_port_chk (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input ptxyz_pkg::ptxyz_out_t out_data_o
);

  // A stalled result holds its value.
  `PTXYZ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result changed")

  // Input back-pressure only comes from a blocked output.
  `PTXYZ_ASSERT_NOW(a_stall_src, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i, "input stalled without a blocked output")

  // A singular system reports the origin.
  `PTXYZ_ASSERT_NOW(a_sing_zero, clk_i, rst_ni, out_valid_o && out_data_o.singular, (out_data_o.point_x == 0) && (out_data_o.point_y == 0) && (out_data_o.point_z == 0), "singular result with nonzero point")

endmodule

bind phase_triangulation_to_xyz_unit ptxyz_port_chk u_ptxyz_port_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ----- verif/ptxyz_checker.sv -----
// Checker that predicts and compares the results of the triangulation unit.
module ptxyz_checker
  import ptxyz_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  ptxyz_in_t  in_data_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  ptxyz_out_t out_data_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output int         fail_count_o,
  output int         pending_o
);

  typedef logic signed [255:0] wide_t;

  logic [63:0] calib_q [7];
  ptxyz_out_t  points_q [$];

  function automatic wide_t hi_word(input logic [63:0] v);
    logic signed [31:0] w;
    w = v[63:32];
    return wide_t'(w);
  endfunction

  function automatic wide_t lo_word(input logic [63:0] v);
    logic signed [31:0] w;
    w = v[31:0];
    return wide_t'(w);
  endfunction

  function automatic wide_t round_q16(input wide_t x);
    return (x + 32768) >>> 16;
  endfunction

  // round(num * 2^16 / den) half away from zero, saturated to 32 bits
  function automatic logic [31:0] coord_quot(input wide_t num, input wide_t den);
    logic  neg;
    wide_t n, d, q, lim;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = ((n <<< 17) + d) / (d <<< 1);
    lim = neg ? wide_t'(64'h8000_0000) : wide_t'(64'h7FFF_FFFF);
    if (q > lim) q = lim;
    q = neg ? -q : q;
    return q[31:0];
  endfunction

  function automatic ptxyz_out_t triangulate(input ptxyz_in_t px);
    ptxyz_out_t res;
    wide_t fx, sk, cx, fy, cy, sc, a1, a2, a3, a4, b1, b2, b3, b4;
    wide_t ph, p, m13, m23, m31, m32, m33, r, c31, c32, c33, det;
    fx = hi_word(calib_q[REG_CAM_FX_SKEW]);    sk = lo_word(calib_q[REG_CAM_FX_SKEW]);
    cx = hi_word(calib_q[REG_CAM_CX_FY]);      fy = lo_word(calib_q[REG_CAM_CX_FY]);
    cy = hi_word(calib_q[REG_CAM_CY_SCALE]);   sc = lo_word(calib_q[REG_CAM_CY_SCALE]);
    a1 = hi_word(calib_q[REG_PROJ_R2_FIRST]);  a2 = lo_word(calib_q[REG_PROJ_R2_FIRST]);
    a3 = hi_word(calib_q[REG_PROJ_R2_SECND]);  a4 = lo_word(calib_q[REG_PROJ_R2_SECND]);
    b1 = hi_word(calib_q[REG_PROJ_R3_FIRST]);  b2 = lo_word(calib_q[REG_PROJ_R3_FIRST]);
    b3 = hi_word(calib_q[REG_PROJ_R3_SECND]);  b4 = lo_word(calib_q[REG_PROJ_R3_SECND]);
    ph = wide_t'(px.abs_phase);
    // projector coordinate, saturated to 32 bits
    p = round_q16(ph * sc);
    if (p > 64'sh7FFF_FFFF) p = 64'sh7FFF_FFFF;
    if (p < -64'sh8000_0000) p = -64'sh8000_0000;
    // 12-bit indices never exceed the 4096 limits, so no clamp is needed
    m13 = cx - (wide_t'(px.pixel_col) + 1) * 65536;
    m23 = cy - (wide_t'(px.pixel_row) + 1) * 65536;
    m31 = a1 - round_q16(p * b1);
    m32 = a2 - round_q16(p * b2);
    m33 = a3 - round_q16(p * b3);
    r   = round_q16(p * b4) - a4;
    c31 = sk * m23 - m13 * fy;
    c32 = -(fx * m23);
    c33 = fx * fy;
    det = c31 * m31 + c32 * m32 + c33 * m33;
    if (det == 0) begin
      res = '0;
      res.singular = 1'b1;
    end else begin
      res.point_x  = coord_quot(c31 * r, det);
      res.point_y  = coord_quot(c32 * r, det);
      res.point_z  = coord_quot(c33 * r, det);
      res.singular = 1'b0;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ptxyz_out_t exp_pt;
    if (!rst_ni) begin
      foreach (calib_q[k]) calib_q[k] = '0;
      points_q.delete();
      fail_count_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) points_q.insert(points_q.size(), triangulate(in_data_i));
      if (cfg_valid_i && cfg_ready_i && cfg_index_i < 7) calib_q[cfg_index_i] = cfg_data_i;
      if (out_valid_i && !out_stall_i) begin
        if (points_q.size() == 0) begin
          $error("unexpected result %h", out_data_i);
          fail_count_o++;
        end else begin
          exp_pt = points_q.pop_front();
          if (out_data_i.point_x !== exp_pt.point_x) begin
            $error("point_x expected %h actual %h", exp_pt.point_x, out_data_i.point_x);
            fail_count_o++;
          end
          if (out_data_i.point_y !== exp_pt.point_y) begin
            $error("point_y expected %h actual %h", exp_pt.point_y, out_data_i.point_y);
            fail_count_o++;
          end
          if (out_data_i.point_z !== exp_pt.point_z) begin
            $error("point_z expected %h actual %h", exp_pt.point_z, out_data_i.point_z);
            fail_count_o++;
          end
          if (out_data_i.singular !== exp_pt.singular) begin
            $error("singular expected %b actual %b", exp_pt.singular, out_data_i.singular);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = points_q.size();
  end

endmodule

// ----- verif/tb_top.sv -----
// Stimulus and verdict for the phase triangulation unit.
module tb_top;
  import ptxyz_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 60;    // extra wait once every result has come

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  ptxyz_in_t  in_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  ptxyz_out_t out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  int fail_count, pending;
  int send_idle_pct, recv_stall_pct;
  int cycle_count;
  bit hold_req;
  bit in_took;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  phase_triangulation_to_xyz_unit uut (.*);

  ptxyz_checker chk (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Record whether the input transfer happened at this edge.
  always @(posedge clk_i) begin
    in_took <= in_valid_i && !in_stall_o;
  end

  // Watchdog: end the run if the unit hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL phase_triangulation_to_xyz_unit");
      $finish;
    end
  end

  // Receiver: random stall, with a long hold-off when requested.
  always @(negedge clk_i) begin
    int hold_left;
    if (hold_req) begin
      hold_left = 300;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Offer one pixel; drop valid only for a random idle gap.
  task automatic send_pixel(input ptxyz_in_t px);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    @(negedge clk_i);
    while (!in_took) @(negedge clk_i);
  endtask

  task automatic send_random(input int count);
    ptxyz_in_t px;
    repeat (count) begin
      px.pixel_row = $urandom_range(4095);
      px.pixel_col = $urandom_range(4095);
      case ($urandom_range(3))
        0:       px.abs_phase = $urandom;
        1:       px.abs_phase = $signed($urandom_range(400 << 16)) - (200 << 16);
        default: px.abs_phase = $urandom_range(100 << 16);
      endcase
      send_pixel(px);
    end
  endtask

  // Wait until every result has come, then wait out DRAIN_WAIT.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  // Write all seven calibration registers; call only while the unit is idle.
  task automatic load_calib(input logic [63:0] vals [7]);
    ptxyz_reg_e idx;
    idx = idx.first();
    for (int k = 0; k < 7; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= vals[k];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      @(negedge clk_i);
      idx = idx.next();
    end
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // A plausible camera/projector pair with some random variation.
  function automatic void plausible_calib(output logic [63:0] vals [7]);
    logic [31:0] fx, fy;
    fx = (32'd900 + $urandom_range(200)) << 16;
    fy = (32'd900 + $urandom_range(200)) << 16;
    vals[REG_CAM_FX_SKEW]   = {fx, 32'($urandom_range(1 << 16))};
    vals[REG_CAM_CX_FY]     = {32'd2048 << 16, fy};
    vals[REG_CAM_CY_SCALE]  = {32'd2048 << 16, 32'($urandom_range(8 << 16, 1 << 14))};
    vals[REG_PROJ_R2_FIRST] = {32'($urandom_range(1 << 20)), 32'd800 << 16};
    vals[REG_PROJ_R2_SECND] = {32'd400 << 16, $urandom};
    vals[REG_PROJ_R3_FIRST] = {32'($urandom_range(1 << 12)), 32'($urandom_range(1 << 12))};
    vals[REG_PROJ_R3_SECND] = {32'd1 << 16, $urandom};
  endfunction

  initial begin
    logic [63:0] calib [7];
    ptxyz_in_t px;
    send_idle_pct = 29;
    recv_stall_pct = 63;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset calibration is all zero: every pixel must come out singular.
    px = '{pixel_row: 12'd0, pixel_col: 12'd0, abs_phase: 32'sd0};
    send_pixel(px);
    px = '{pixel_row: 12'hFFF, pixel_col: 12'hFFF, abs_phase: 32'h7FFF_FFFF};
    send_pixel(px);
    drain();

    // Directed corners with a plausible setup.
    plausible_calib(calib);
    load_calib(calib);
    for (int k = 0; k < 16; k++) begin
      px.pixel_row = k[0] ? 12'hFFF : 12'h000;
      px.pixel_col = k[1] ? 12'hFFF : 12'h000;
      case (k[3:2])
        0:       px.abs_phase = 32'sh8000_0000;
        1:       px.abs_phase = 32'sh7FFF_FFFF;
        2:       px.abs_phase = 32'sd0;
        default: px.abs_phase = 32'sh0032_8000;
      endcase
      send_pixel(px);
    end
    drain();

    // Zero focal x and skew: most terms of the system drop out.
    calib[REG_CAM_FX_SKEW] = 64'h0000_0000_0000_0000;
    load_calib(calib);
    send_random(4);
    drain();

    // Plausible setup; the receiver holds off long while pixels keep coming.
    plausible_calib(calib);
    load_calib(calib);
    hold_req = 1'b1;
    send_random(300);
    drain();

    // Full random register contents.
    foreach (calib[k]) calib[k] = {$urandom, $urandom};
    load_calib(calib);
    send_random(150);
    drain();

    send_idle_pct = 63;
    recv_stall_pct = 29;
    // Extremes: all ones, then largest and smallest words.
    foreach (calib[k]) calib[k] = '1;
    load_calib(calib);
    send_random(100);
    drain();
    foreach (calib[k]) calib[k] = 64'h7FFF_FFFF_8000_0000;
    load_calib(calib);
    send_random(100);
    drain();

    plausible_calib(calib);
    load_calib(calib);
    send_random(250);
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    foreach (calib[k]) calib[k] = {$urandom, $urandom};
    load_calib(calib);
    send_random(100);
    drain();
    plausible_calib(calib);
    load_calib(calib);
    send_random(250);
    drain();

    if (fail_count == 0) begin
      $display("PASS phase_triangulation_to_xyz_unit");
    end else begin
      $display("FAIL phase_triangulation_to_xyz_unit");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/ptxyz_pkg.sv
rtl/ptxyz_div.sv
rtl/phase_triangulation_to_xyz_unit.sv
rtl/ptxyz_checker.sv
verif/ptxyz_checker.sv
verif/tb_top.sv
